// ===== rtl/core/pid4_pkg.sv =====
// pid4_pkg: shared constants, word types and the configuration bus of the
// four-axis PID regulator. No dependencies.
package pid4_pkg;

   // Axis and bank sizing
   localparam int AXIS_COUNT_DEFAULT = 4;
   localparam int BANK_COUNT         = 4;
   localparam int BANK_W             = 2;
   localparam int AXIS_W             = 2;

   // Fixed-point field widths
   localparam int ERR_W    = 24;   // Q15.8 error sample
   localparam int GAIN_W   = 16;   // Q7.8 gain
   localparam int GAINS_W  = 3 * GAIN_W;
   localparam int LIMIT_W  = 23;   // unsigned Q15.8 increment bound
   localparam int ACC_W    = 40;   // Q31.8 accumulator
   localparam int DRIVE_W  = 32;   // Q23.8 output
   localparam int FRAC_W   = 8;

   // Register port
   localparam int REG_W     = 64;
   localparam int ADDR_W    = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_LIMIT_BASE = 3'd4;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 23'd256000;

   typedef enum logic {
      MODE_UPDATE  = 1'b0,
      MODE_RESTART = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [AXIS_W-1:0]        axis;
      logic signed [ERR_W-1:0]  error_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic [AXIS_W-1:0]         drive_axis;
   } rsp_word_type;

   // Gains as packed in the register: D 47:32, I 31:16, P 15:0
   typedef struct packed {
      logic signed [GAIN_W-1:0] d_gain;
      logic signed [GAIN_W-1:0] i_gain;
      logic signed [GAIN_W-1:0] p_gain;
   } gains_type;

   typedef struct packed {
      gains_type [BANK_COUNT-1:0]             gains;
      logic [BANK_COUNT-1:0][LIMIT_W-1:0]     limit;
   } csr_bus_type;

   // One entry of the per-axis state memory
   typedef struct packed {
      logic signed [ACC_W-1:0] acc;
      logic signed [ERR_W-1:0] prev;
   } axis_state_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } pipe_result_type;

endpackage

// ===== rtl/core/pid4_ram.sv =====
// pid4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pid4_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; a read of the same entry in the same cycle returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pid4_csr.sv =====
// pid4_csr: APB-style register file for the per-axis gains and increment limits.
// Depends on pid4_pkg.
module pid4_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pid4_pkg::ADDR_W-1:0]       paddr,
   input  logic [pid4_pkg::REG_W-1:0]        pwdata,
   output logic [pid4_pkg::REG_W-1:0]        prdata,
   output logic                              pready,
   output pid4_pkg::csr_bus_type             cfg
);

   pid4_pkg::gains_type [pid4_pkg::BANK_COUNT-1:0]              gains_ff, gains_in;
   logic [pid4_pkg::BANK_COUNT-1:0][pid4_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic [pid4_pkg::REG_IDX_W-1:0]                              reg_idx;
   logic [pid4_pkg::BANK_W-1:0]                                 bank;
   logic                                                        wr_strobe;

   // 8-byte register spacing
   assign reg_idx   = paddr[pid4_pkg::ADDR_W-1:3];
   assign bank      = reg_idx[pid4_pkg::BANK_W-1:0];
   assign wr_strobe = psel & penable & pwrite;
   assign pready    = 1'b1;

   // Next register values
   always_comb begin
      gains_in = gains_ff;
      limit_in = limit_ff;
      if (wr_strobe) begin
         if (reg_idx < pid4_pkg::REG_LIMIT_BASE) begin
            gains_in[bank] = pid4_pkg::gains_type'(pwdata[pid4_pkg::GAINS_W-1:0]);
         end else begin
            limit_in[bank] = pwdata[pid4_pkg::LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
         for (int b = 0; b < pid4_pkg::BANK_COUNT; b++) begin
            limit_ff[b] <= pid4_pkg::LIMIT_RESET;
         end
      end else begin
         gains_ff <= gains_in;
         limit_ff <= limit_in;
      end
   end

   // Read-back, zero-extended
   always_comb begin
      if (reg_idx < pid4_pkg::REG_LIMIT_BASE) begin
         prdata = {{(pid4_pkg::REG_W - pid4_pkg::GAINS_W){1'b0}}, gains_ff[bank]};
      end else begin
         prdata = {{(pid4_pkg::REG_W - pid4_pkg::LIMIT_W){1'b0}}, limit_ff[bank]};
      end
   end

   assign cfg.gains = gains_ff;
   assign cfg.limit = limit_ff;

endmodule

// ===== rtl/core/pid4_pipe.sv =====
// pid4_pipe: read-modify-write pipeline over the per-axis state memory:
// state read, gain products, integrator update and write-back, output sum.
// Depends on pid4_pkg and pid4_ram.
module pid4_pipe #(
   parameter int AXIS_COUNT = pid4_pkg::AXIS_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       req_valid,
   input  pid4_pkg::req_word_type     req_word,
   input  pid4_pkg::csr_bus_type      cfg,
   output pid4_pkg::pipe_result_type  result
);

   localparam int AW      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int SW      = $bits(pid4_pkg::axis_state_type);
   localparam int ERR_W   = pid4_pkg::ERR_W;
   localparam int ACC_W   = pid4_pkg::ACC_W;
   localparam int FRAC_W  = pid4_pkg::FRAC_W;
   localparam int PROD_W  = pid4_pkg::GAIN_W + ERR_W;       // gain * error
   localparam int DIFF_W  = ERR_W + 1;                       // error difference
   localparam int DPROD_W = pid4_pkg::GAIN_W + DIFF_W;      // gain * difference
   localparam int TERM_W  = PROD_W - FRAC_W;                 // P and I terms
   localparam int DTERM_W = DPROD_W - FRAC_W;                // D term
   localparam int LIMX_W  = TERM_W + 1;                      // clamp compare width
   localparam int INC_W   = pid4_pkg::LIMIT_W + 1;           // clamped increment
   localparam int PD_W    = DTERM_W + 1;                     // P + D
   localparam int TOT_W   = ACC_W + 1;                       // full output sum
   localparam int DRIVE_W = pid4_pkg::DRIVE_W;
   localparam int AXIS_W  = pid4_pkg::AXIS_W;

   // ---------------- accept ----------------
   logic                     accept, in_range, upd_go;
   logic [2:0]               axis_ext;
   logic [AW-1:0]            req_addr;
   logic [AXIS_COUNT-1:0]    pending_ff, pending_in;

   assign accept   = req_valid & en;
   assign in_range = int'(req_word.axis) < AXIS_COUNT;
   assign axis_ext = {1'b0, req_word.axis};
   assign req_addr = axis_ext[AW-1:0];
   assign upd_go   = accept & (req_word.mode == pid4_pkg::MODE_UPDATE) & in_range;

   // Pending-restart bits: set all on a restart word, claim one on an update
   always_comb begin
      pending_in = pending_ff;
      if (accept) begin
         if (req_word.mode == pid4_pkg::MODE_RESTART) begin
            pending_in = '1;
         end else if (in_range) begin
            pending_in[req_addr] = 1'b0;
         end
      end
   end

   // ---------------- stage registers ----------------
   logic                         s1_valid_ff, s1_clear_ff;
   logic [AXIS_W-1:0]            s1_axis_ff;
   logic signed [ERR_W-1:0]      s1_e_ff;

   logic                         s2_valid_ff;
   logic [AXIS_W-1:0]            s2_axis_ff;
   logic signed [ERR_W-1:0]      s2_e_ff;
   logic signed [PROD_W-1:0]     s2_pe_ff, s2_ie_ff;
   logic signed [DPROD_W-1:0]    s2_de_ff;
   logic signed [ACC_W-1:0]      s2_acc_ff;

   logic                         s3_valid_ff;
   logic [AXIS_W-1:0]            s3_axis_ff;
   logic signed [ACC_W-1:0]      s3_acc_ff;
   logic signed [PD_W-1:0]       s3_pd_ff;

   logic                         wb_valid_ff;
   logic [AXIS_W-1:0]            wb_axis_ff;
   pid4_pkg::axis_state_type     wb_state_ff;

   // ---------------- state memory ----------------
   pid4_pkg::axis_state_type     ram_q, wr_state;
   logic [2:0]                   s2_axis_ext;
   logic [AW-1:0]                wr_addr;
   logic signed [ACC_W-1:0]      acc_new;

   assign s2_axis_ext   = {1'b0, s2_axis_ff};
   assign wr_addr       = s2_axis_ext[AW-1:0];
   assign wr_state.acc  = acc_new;
   assign wr_state.prev = s2_e_ff;

   pid4_ram #(
      .WIDTH (SW),
      .DEPTH (AXIS_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (en & s2_valid_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_state),
      .rd_en   (en),
      .rd_addr (req_addr),
      .rd_data (ram_q)
   );

   // ---------------- stage 1: forward state, form products ----------------
   pid4_pkg::axis_state_type     s1_state;
   pid4_pkg::gains_type          s1_gains;
   logic signed [DIFF_W-1:0]     s1_diff;
   logic signed [PROD_W-1:0]     s2_pe_in, s2_ie_in;
   logic signed [DPROD_W-1:0]    s2_de_in;

   // Newest copy of the entry: the write in flight this cycle, then the one
   // written at the read edge, then memory
   always_comb begin
      priority if (s1_clear_ff) begin
         s1_state = '0;
      end else if (s2_valid_ff && (s2_axis_ff == s1_axis_ff)) begin
         s1_state = wr_state;
      end else if (wb_valid_ff && (wb_axis_ff == s1_axis_ff)) begin
         s1_state = wb_state_ff;
      end else begin
         s1_state = ram_q;
      end
   end

   assign s1_gains = cfg.gains[s1_axis_ff];
   assign s1_diff  = $signed({s1_e_ff[ERR_W-1], s1_e_ff})
                   - $signed({s1_state.prev[ERR_W-1], s1_state.prev});
   assign s2_pe_in = $signed(s1_gains.p_gain) * $signed(s1_e_ff);
   assign s2_ie_in = $signed(s1_gains.i_gain) * $signed(s1_e_ff);
   assign s2_de_in = $signed(s1_gains.d_gain) * $signed(s1_diff);

   // ---------------- stage 2: clamp increment, integrate, P + D ----------------
   logic signed [TERM_W-1:0]     i_term, p_term;
   logic signed [DTERM_W-1:0]    d_term;
   logic signed [LIMX_W-1:0]     i_term_x, lim_x, neg_lim_x;
   logic signed [INC_W-1:0]      inc;
   logic signed [ACC_W:0]        acc_sum;
   logic signed [PD_W-1:0]       s3_pd_in;

   // Arithmetic shift right drops the Q.16 products back to Q.8 (floor)
   assign i_term    = s2_ie_ff[PROD_W-1:FRAC_W];
   assign p_term    = s2_pe_ff[PROD_W-1:FRAC_W];
   assign d_term    = s2_de_ff[DPROD_W-1:FRAC_W];
   assign i_term_x  = {i_term[TERM_W-1], i_term};
   assign lim_x     = {{(LIMX_W - pid4_pkg::LIMIT_W){1'b0}}, cfg.limit[s2_axis_ff]};
   assign neg_lim_x = -lim_x;

   always_comb begin
      priority if (i_term_x > lim_x) begin
         inc = lim_x[INC_W-1:0];
      end else if (i_term_x < neg_lim_x) begin
         inc = neg_lim_x[INC_W-1:0];
      end else begin
         inc = i_term_x[INC_W-1:0];
      end
   end

   assign acc_sum = {s2_acc_ff[ACC_W-1], s2_acc_ff}
                  + {{(ACC_W + 1 - INC_W){inc[INC_W-1]}}, inc};

   // Saturate the accumulator to its 40-bit range
   always_comb begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                  : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_new = acc_sum[ACC_W-1:0];
      end
   end

   assign s3_pd_in = {{(PD_W - TERM_W){p_term[TERM_W-1]}}, p_term}
                   + {d_term[DTERM_W-1], d_term};

   // ---------------- stage 3: output sum and saturation ----------------
   logic signed [TOT_W-1:0]      total;
   logic                         total_fits;
   logic signed [DRIVE_W-1:0]    drive;

   assign total = {s3_acc_ff[ACC_W-1], s3_acc_ff}
                + {{(TOT_W - PD_W){s3_pd_ff[PD_W-1]}}, s3_pd_ff};
   assign total_fits = (&total[TOT_W-1:DRIVE_W-1]) | ~(|total[TOT_W-1:DRIVE_W-1]);

   always_comb begin
      if (total_fits) begin
         drive = total[DRIVE_W-1:0];
      end else begin
         drive = total[TOT_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                : {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   assign result.valid           = s3_valid_ff;
   assign result.word.drive      = drive;
   assign result.word.drive_axis = s3_axis_ff;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (en) begin
            s1_valid_ff <= upd_go;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            wb_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         s1_clear_ff <= pending_ff[req_addr];
         s1_axis_ff  <= req_word.axis;
         s1_e_ff     <= req_word.error_sample;

         s2_axis_ff  <= s1_axis_ff;
         s2_e_ff     <= s1_e_ff;
         s2_pe_ff    <= s2_pe_in;
         s2_ie_ff    <= s2_ie_in;
         s2_de_ff    <= s2_de_in;
         s2_acc_ff   <= s1_state.acc;

         s3_axis_ff  <= s2_axis_ff;
         s3_acc_ff   <= acc_new;
         s3_pd_ff    <= s3_pd_in;

         wb_axis_ff  <= s2_axis_ff;
         wb_state_ff <= wr_state;
      end
   end

   // ---------------- assertions ----------------
   a_restart_marks_all: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.mode == pid4_pkg::MODE_RESTART) |=> (&pending_ff))
      else $error("restart word did not mark every axis pending");

   a_update_claims_pending: assert property (@(posedge clock) disable iff (reset)
      upd_go |=> !pending_ff[$past(req_addr)])
      else $error("update left its axis pending");

   a_write_follows_stage2: assert property (@(posedge clock) disable iff (reset)
      en && s2_valid_ff |=> wb_valid_ff && (wb_axis_ff == $past(s2_axis_ff)))
      else $error("write-back record lost an update");

endmodule

// ===== rtl/core/four_axis_pid_regulator_core.sv =====
// Four-axis PID regulator. Each update word names an axis and carries a Q15.8
// error sample; one drive word (Q23.8, saturated) comes back per update, in
// order. A restart word marks all axes pending and returns nothing; the next
// update of a pending axis starts from a zero accumulator and a zero previous
// error. Gains and increment limits sit in eight 64-bit registers at byte
// addresses 8*i (gains for axes 0-3, then limits for axes 0-3). The block
// takes one word per clock while req_ready is high: the per-axis state lives
// in a single-port-read RAM, read at accept and written back from stage 2,
// with forwarding for back-to-back updates of the same axis. Each update
// passes stages 1, 2 and 3 and then the output register before rsp_valid
// rises; a two-deep output buffer lets intake run on while a result waits,
// and req_ready drops once the second slot fills, until the consumer takes
// a word. No clearing pass is needed after reset.
// Depends on pid4_pkg, pid4_csr, pid4_pipe and pid4_ram.
module four_axis_pid_regulator_core #(
   parameter int AXIS_COUNT = pid4_pkg::AXIS_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pid4_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pid4_pkg::rsp_word_type            rsp_word,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pid4_pkg::ADDR_W-1:0]       paddr,
   input  logic [pid4_pkg::REG_W-1:0]        pwdata,
   output logic [pid4_pkg::REG_W-1:0]        prdata,
   output logic                              pready
);

   pid4_pkg::csr_bus_type       cfg;
   pid4_pkg::pipe_result_type   result;
   logic                        en;
   logic                        out_valid_ff, skid_valid_ff;
   pid4_pkg::rsp_word_type      out_word_ff, skid_word_ff;
   logic                        take;

   pid4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Pipeline advances while the skid slot is free
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   pid4_pipe #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_word  (req_word),
      .cfg       (cfg),
      .result    (result)
   );

   // Output register with one skid slot behind it
   assign take = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (take && skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (take || !out_valid_ff) begin
            out_valid_ff <= en & result.valid;
         end else if (en && result.valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // A full skid slot keeps its word until it moves to the output register
   always_ff @(posedge clock) begin
      priority if (take && skid_valid_ff) begin
         out_word_ff <= skid_word_ff;
      end else if (take || !out_valid_ff) begin
         out_word_ff <= result.word;
      end else if (!skid_valid_ff) begin
         skid_word_ff <= result.word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a word while the output register is empty");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      take && skid_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("skid word not moved to the output register");

endmodule

// ===== tb/four_axis_pid_regulator_core_tb.sv =====
// Self-checking testbench for the four-axis PID regulator core: directed drill
// table, integrator wind-up run and randomised phases checked against a
// local predictor. Depends on pid4_pkg and four_axis_pid_regulator_core.
`timescale 1ns / 100ps

module four_axis_pid_regulator_core_tb;

   localparam int AXIS_COUNT     = pid4_pkg::AXIS_COUNT_DEFAULT;
   localparam int ERR_W          = pid4_pkg::ERR_W;
   localparam int DRIVE_W        = pid4_pkg::DRIVE_W;
   localparam int AXIS_W         = pid4_pkg::AXIS_W;
   localparam int ADDR_W         = pid4_pkg::ADDR_W;
   localparam int REG_W          = pid4_pkg::REG_W;
   localparam int LIMIT_W        = pid4_pkg::LIMIT_W;
   localparam int GAIN_W         = pid4_pkg::GAIN_W;
   localparam int GAINS_W        = pid4_pkg::GAINS_W;
   localparam int FRAC_W         = pid4_pkg::FRAC_W;
   localparam int REG_GAINS_BASE = 0;
   localparam int REG_COUNT      = 2 * pid4_pkg::BANK_COUNT;
   localparam int SETTLE_CYCLES  = 12;
   localparam int CYCLE_LIMIT    = 3000000;
   localparam int REPORT_CAP     = 100;
   localparam int WINDUP_STEPS   = 16;
   localparam int PHASES         = 4;
   localparam int PHASE_WORDS    = 160;
   localparam int DRILL_ROWS     = 20;
   localparam int DRILL_CFG_ROW  = 6;

   localparam logic signed [ERR_W-1:0]   ERR_HI   = 24'h7FFFFF;
   localparam logic signed [ERR_W-1:0]   ERR_LO   = 24'h800000;
   localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 32'h7FFFFFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_LO = 32'h80000000;
   localparam longint ACC_HI = 64'sd549755813887;
   localparam longint ACC_LO = -64'sd549755813888;
   localparam longint OUT_HI = 64'sd2147483647;
   localparam longint OUT_LO = -64'sd2147483648;

   typedef struct {
      pid4_pkg::mode_type        mode;
      logic [AXIS_W-1:0]         axis;
      logic signed [ERR_W-1:0]   err;
      bit                        pinned;
      logic signed [DRIVE_W-1:0] drive;
   } drill_row_type;

   // DUT connections
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   pid4_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   pid4_pkg::rsp_word_type rsp_word;
   logic                   psel      = 1'b0;
   logic                   penable   = 1'b0;
   logic                   pwrite    = 1'b0;
   logic [ADDR_W-1:0]      paddr     = '0;
   logic [REG_W-1:0]       pwdata    = '0;
   logic [REG_W-1:0]       prdata;
   logic                   pready;

   // Typed-in expectation travelling alongside the request word
   logic                      pin_on    = 1'b0;
   logic signed [DRIVE_W-1:0] pin_drive = '0;

   bit  quiet      = 1'b0;
   int  stall_left = 0;
   int  fault_count = 0;
   int  cycles     = 0;

   // Predictor state and register shadow
   pid4_pkg::gains_type axis_gains  [AXIS_COUNT];
   logic [LIMIT_W-1:0]  axis_limit  [AXIS_COUNT];
   longint              integ_sum   [AXIS_COUNT];
   longint              prev_err    [AXIS_COUNT];
   bit                  restart_due [AXIS_COUNT];

   pid4_pkg::rsp_word_type drive_q [$];

   // Directed drill: reset gains first, then the extreme settings below
   drill_row_type drill [DRILL_ROWS] = '{
      '{pid4_pkg::MODE_UPDATE,  2'd0, ERR_HI,  1'b1, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd1, ERR_LO,  1'b1, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd2, 24'sd0,  1'b1, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd3, -24'sd1, 1'b1, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd3, 24'sd1,  1'b1, 32'sd0},
      '{pid4_pkg::MODE_RESTART, 2'd0, 24'sd0,  1'b0, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd2, ERR_HI,  1'b1, 32'sd8388607},
      '{pid4_pkg::MODE_UPDATE,  2'd2, ERR_LO,  1'b1, -32'sd8388608},
      '{pid4_pkg::MODE_UPDATE,  2'd3, 24'sd1000, 1'b1, 32'sd256},
      '{pid4_pkg::MODE_UPDATE,  2'd3, 24'sd100,  1'b1, 32'sd356},
      '{pid4_pkg::MODE_UPDATE,  2'd3, ERR_LO,  1'b1, 32'sd100},
      '{pid4_pkg::MODE_UPDATE,  2'd0, ERR_HI,  1'b1, DRIVE_HI},
      '{pid4_pkg::MODE_UPDATE,  2'd0, ERR_LO,  1'b1, DRIVE_LO},
      '{pid4_pkg::MODE_UPDATE,  2'd1, ERR_HI,  1'b0, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd1, ERR_LO,  1'b1, DRIVE_HI},
      '{pid4_pkg::MODE_UPDATE,  2'd0, 24'sd0,  1'b0, 32'sd0},
      '{pid4_pkg::MODE_RESTART, 2'd3, ERR_LO,  1'b0, 32'sd0},
      '{pid4_pkg::MODE_UPDATE,  2'd2, -24'sd1, 1'b1, -32'sd1},
      '{pid4_pkg::MODE_UPDATE,  2'd3, 24'sd50, 1'b1, 32'sd50},
      '{pid4_pkg::MODE_UPDATE,  2'd1, 24'sd1,  1'b0, 32'sd0}
   };

   four_axis_pid_regulator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   function automatic longint clamp_ll(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // One PID update of an axis; advances the predictor state
   function automatic logic signed [DRIVE_W-1:0] regulate(input logic [AXIS_W-1:0] ax,
                                                         input logic signed [ERR_W-1:0] sample);
      longint e, pg, ig, dg, lim, i_step, acc, total;
      e   = sample;
      pg  = longint'($signed(axis_gains[ax].p_gain));
      ig  = longint'($signed(axis_gains[ax].i_gain));
      dg  = longint'($signed(axis_gains[ax].d_gain));
      lim = longint'(axis_limit[ax]);
      if (restart_due[ax]) begin
         restart_due[ax] = 1'b0;
         integ_sum[ax]   = 0;
         prev_err[ax]    = 0;
      end
      // products back to Q.8 rounding towards minus infinity
      i_step = clamp_ll((ig * e) >>> FRAC_W, -lim, lim);
      acc    = clamp_ll(integ_sum[ax] + i_step, ACC_LO, ACC_HI);
      integ_sum[ax] = acc;
      total = ((pg * e) >>> FRAC_W) + acc + ((dg * (e - prev_err[ax])) >>> FRAC_W);
      total = clamp_ll(total, OUT_LO, OUT_HI);
      prev_err[ax] = e;
      return DRIVE_W'(total);
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      fault_count++;
      // keep the log readable if a long run goes wrong
      if (fault_count <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Cycle guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Prediction on accepted request words, checking of accepted drive words
   always @(posedge clock) begin : watch
      logic signed [DRIVE_W-1:0] drive_now;
      pid4_pkg::rsp_word_type    want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_word.mode == pid4_pkg::MODE_RESTART) begin
               foreach (restart_due[k]) restart_due[k] = 1'b1;
            end else if (req_word.axis < AXIS_COUNT) begin
               drive_now = regulate(req_word.axis, req_word.error_sample);
               drive_q.push_back('{drive: pin_on ? pin_drive : drive_now,
                                   drive_axis: req_word.axis});
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_q.size() == 0) begin
               fault_count++;
               $display("%0t: drive word with none expected, actual drive %0d axis %0d",
                        $time, rsp_word.drive, rsp_word.drive_axis);
            end else begin
               want = drive_q.pop_front();
               if (rsp_word.drive !== want.drive)
                  flag_mismatch("drive", want.drive, rsp_word.drive);
               if (rsp_word.drive_axis !== want.drive_axis)
                  flag_mismatch("drive_axis", want.drive_axis, rsp_word.drive_axis);
            end
         end
      end
   end

   // Register write: setup phase, access phase held until pready, then an idle gap
   task automatic csr_write(input int idx, input logic [REG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx < pid4_pkg::REG_LIMIT_BASE)
         axis_gains[idx - REG_GAINS_BASE] = value[GAINS_W-1:0];
      else
         axis_limit[idx - pid4_pkg::REG_LIMIT_BASE] = value[LIMIT_W-1:0];
      @(posedge clock);
   endtask

   // Present one request word, with an optional idle burst in front
   task automatic send_word(input pid4_pkg::req_word_type w, input bit pinned,
                            input logic signed [DRIVE_W-1:0] want);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      pin_on    <= pinned;
      pin_drive <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop intake and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0: case ($urandom_range(0, 2))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               default: return 16'h0000;
            endcase
         1:       return GAIN_W'($urandom_range(0, 1024) - 512);
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return LIMIT_W'($urandom_range(0, 4096));
         default: return LIMIT_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [ERR_W-1:0] pick_error();
      case ($urandom_range(0, 3))
         0: case ($urandom_range(0, 4))
               0:       return ERR_HI;
               1:       return ERR_LO;
               2:       return '0;
               3:       return 24'sd1;
               default: return -24'sd1;
            endcase
         1:       return ERR_W'($urandom_range(0, 4000) - 2000);
         default: return ERR_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      pid4_pkg::req_word_type w;
      logic [REG_W-1:0]       value;
      for (int k = 0; k < AXIS_COUNT; k++) begin
         axis_gains[k]  = '0;
         axis_limit[k]  = pid4_pkg::LIMIT_RESET;
         integ_sum[k]   = 0;
         prev_err[k]    = 0;
         restart_due[k] = 1'b1;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed drill; register values carry junk above the field width
      for (int i = 0; i < DRILL_ROWS; i++) begin
         if (i == DRILL_CFG_ROW) begin
            settle();
            csr_write(REG_GAINS_BASE + 0, 64'hA5A5_7FFF_7FFF_7FFF);
            csr_write(REG_GAINS_BASE + 1, 64'h0000_8000_8000_8000);
            csr_write(REG_GAINS_BASE + 2, 64'h0000_0000_0000_0100);
            csr_write(REG_GAINS_BASE + 3, 64'hFFFF_0000_0100_0000);
            csr_write(pid4_pkg::REG_LIMIT_BASE + 0, 64'hFFFF_FFFF_FFFF_FFFF);
            csr_write(pid4_pkg::REG_LIMIT_BASE + 1, 64'hFFFF_FFFF_FF80_0000);
            csr_write(pid4_pkg::REG_LIMIT_BASE + 2, 64'd256000);
            csr_write(pid4_pkg::REG_LIMIT_BASE + 3, 64'h8000_0000_0000_0100);
         end
         w.mode         = drill[i].mode;
         w.axis         = drill[i].axis;
         w.error_sample = drill[i].err;
         send_word(w, drill[i].pinned, drill[i].drive);
      end
      settle();

      // Wind both integrators hard at the full increment, one up and one down
      quiet <= 1'b1;
      csr_write(REG_GAINS_BASE + 0, 64'h0000_0000_7FFF_0000);
      csr_write(REG_GAINS_BASE + 1, 64'h0000_0000_7FFF_0000);
      csr_write(pid4_pkg::REG_LIMIT_BASE + 0, 64'h7F_FFFF);
      csr_write(pid4_pkg::REG_LIMIT_BASE + 1, 64'h7F_FFFF);
      w.mode = pid4_pkg::MODE_UPDATE;
      for (int k = 0; k < WINDUP_STEPS; k++) begin
         w.axis         = 2'd0;
         w.error_sample = ERR_HI;
         send_word(w, 1'b0, '0);
         w.axis         = 2'd1;
         w.error_sample = ERR_LO;
         send_word(w, 1'b0, '0);
      end
      settle();

      // Random phases, fresh register settings each; last phase runs flat out
      for (int ph = 0; ph < PHASES; ph++) begin
         quiet <= (ph == PHASES - 1);
         for (int r = 0; r < REG_COUNT; r++) begin
            value = {$urandom, $urandom};
            if (r < pid4_pkg::REG_LIMIT_BASE)
               value[GAINS_W-1:0] = {pick_gain(), pick_gain(), pick_gain()};
            else
               value[LIMIT_W-1:0] = pick_limit();
            csr_write(r, value);
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            w.mode         = ($urandom_range(0, 11) == 0) ? pid4_pkg::MODE_RESTART
                                                          : pid4_pkg::MODE_UPDATE;
            w.axis         = AXIS_W'($urandom);
            w.error_sample = pick_error();
            send_word(w, 1'b0, '0);
         end
         settle();
      end

      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
